// ----- sv/lru_pkg.sv -----
package lru_pkg;

  localparam int MAX_FRAMES_DEF = 8;
  localparam int PAGE_BITS_DEF  = 8;
  localparam int COUNT_BITS_DEF = 16;

  localparam int CFG_BITS = 4;
  localparam logic [CFG_BITS-1:0] FRAMES_IN_USE_RST = CFG_BITS'(4);

  typedef struct packed {
    logic load_in;
    logic commit;
    logic cfg_we;
  } ctrl_cmd_t;

endpackage

// ----- sv/lru_if.sv -----
interface lru_req_if #(
  parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 restart;
  logic [PAGE_BITS-1:0] page_number;

  modport source (output valid, output restart, output page_number, input ready);
  modport sink   (input valid, input restart, input page_number, output ready);
endinterface

interface lru_rsp_if #(
  parameter int MAX_FRAMES = lru_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = lru_pkg::PAGE_BITS_DEF,
  parameter int COUNT_BITS = lru_pkg::COUNT_BITS_DEF
);
  localparam int FRAME_BITS = $clog2(MAX_FRAMES);

  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [FRAME_BITS-1:0] frame_index;
  logic                  evicted_valid;
  logic [PAGE_BITS-1:0]  evicted_page;
  logic [COUNT_BITS-1:0] fault_count;
  logic [COUNT_BITS-1:0] replace_count;

  modport source (output valid, output hit, output frame_index, output evicted_valid,
                  output evicted_page, output fault_count, output replace_count,
                  input ready);
  modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                  input evicted_page, input fault_count, input replace_count,
                  output ready);
endinterface

interface lru_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lru_pkg::CFG_BITS-1:0]  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/lru_page_replacement_top.sv -----
// A request is registered on accept and its result at commit; a new
// request is taken only after that commit. The frame search, victim pick
// and rank update run in the execute state, which holds off commit while a
// result is pending; a pending result does not block the next accept.
// Reset (rst_n low, synchronous): all frames empty, ranks and counts zero,
// frames_in_use 4; frame page contents are left as they are.
module lru_page_replacement_top #(
  parameter int MAX_FRAMES = lru_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = lru_pkg::PAGE_BITS_DEF,
  parameter int COUNT_BITS = lru_pkg::COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  lru_req_if.sink          in_chan,
  lru_rsp_if.source        out_chan,
  lru_cfg_if.sink          cfg_chan
);
  import lru_pkg::*;

  ctrl_cmd_t cmd;
  logic      in_ready;
  logic      out_valid;
  logic      cfg_ready;

  lru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .cfg_valid (cfg_chan.valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  lru_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_restart        (in_chan.restart),
    .in_page_number    (in_chan.page_number),
    .cfg_data          (cfg_chan.data),
    .out_hit           (out_chan.hit),
    .out_frame_index   (out_chan.frame_index),
    .out_evicted_valid (out_chan.evicted_valid),
    .out_evicted_page  (out_chan.evicted_page),
    .out_fault_count   (out_chan.fault_count),
    .out_replace_count (out_chan.replace_count)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;
  assign cfg_chan.ready = cfg_ready;

endmodule

// ----- sv/lru_ctrl.sv -----
module lru_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  output lru_pkg::ctrl_cmd_t cmd
);
  import lru_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.cfg_we    = cfg_valid;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

  a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("commit over a pending result");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");

  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_in |=> (state_r == ST_EXEC) && !in_ready)
    else $error("request taken without entering execute");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load_in && cmd.commit))
    else $error("load and commit in the same cycle");

endmodule

// ----- sv/lru_dp.sv -----
module lru_dp #(
  parameter int MAX_FRAMES = lru_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = lru_pkg::PAGE_BITS_DEF,
  parameter int COUNT_BITS = lru_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lru_pkg::ctrl_cmd_t               cmd,
  input  logic                             in_restart,
  input  logic [PAGE_BITS-1:0]             in_page_number,
  input  logic [lru_pkg::CFG_BITS-1:0]     cfg_data,
  output logic                             out_hit,
  output logic [$clog2(MAX_FRAMES)-1:0]    out_frame_index,
  output logic                             out_evicted_valid,
  output logic [PAGE_BITS-1:0]             out_evicted_page,
  output logic [COUNT_BITS-1:0]            out_fault_count,
  output logic [COUNT_BITS-1:0]            out_replace_count
);
  import lru_pkg::*;

  localparam int FRAME_BITS = $clog2(MAX_FRAMES);
  localparam int RANK_BITS  = $clog2(MAX_FRAMES);
  localparam int NB         = $clog2(MAX_FRAMES + 1);
  localparam int NW         = (CFG_BITS > NB) ? CFG_BITS : NB;
  localparam logic [RANK_BITS-1:0] RANK_TOP = RANK_BITS'(MAX_FRAMES - 1);

  logic                  restart_r;
  logic [PAGE_BITS-1:0]  page_r;
  logic [CFG_BITS-1:0]   cfg_r;

  logic [PAGE_BITS-1:0]  frame_page_r [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] frame_valid_r, frame_valid_nxt;
  logic [RANK_BITS-1:0]  rank_r   [MAX_FRAMES];
  logic [RANK_BITS-1:0]  rank_nxt [MAX_FRAMES];
  logic [COUNT_BITS-1:0] faults_r, faults_nxt;
  logic [COUNT_BITS-1:0] repl_r, repl_nxt;

  logic                  hit_r;
  logic [FRAME_BITS-1:0] frame_r;
  logic                  ev_valid_r;
  logic [PAGE_BITS-1:0]  ev_page_r;

  logic [NW-1:0]         n_raw, n_eff;
  logic [MAX_FRAMES-1:0] vld_e;
  logic [RANK_BITS-1:0]  rank_e [MAX_FRAMES];
  logic [COUNT_BITS-1:0] faults_e, repl_e;
  logic                  hit_found, emp_found, vic_found, evict;
  logic [FRAME_BITS-1:0] hit_idx, emp_idx, vic_idx, frame_sel;
  logic [RANK_BITS-1:0]  vic_rank;
  logic [RANK_BITS:0]    old_rank;
  logic [PAGE_BITS-1:0]  ev_page;

  always_comb begin
    n_raw = NW'(cfg_r);
    if (n_raw == '0) begin
      n_eff = NW'(1);
    end else if (n_raw > NW'(MAX_FRAMES)) begin
      n_eff = NW'(MAX_FRAMES);
    end else begin
      n_eff = n_raw;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      vld_e[i]  = restart_r ? 1'b0 : frame_valid_r[i];
      rank_e[i] = restart_r ? '0 : rank_r[i];
    end
    faults_e = restart_r ? '0 : faults_r;
    repl_e   = restart_r ? '0 : repl_r;
  end

  always_comb begin
    hit_found = 1'b0;
    hit_idx   = '0;
    emp_found = 1'b0;
    emp_idx   = '0;
    vic_found = 1'b0;
    vic_idx   = '0;
    vic_rank  = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (NW'(i) < n_eff) begin
        if (vld_e[i]) begin
          if (!hit_found && frame_page_r[i] == page_r) begin
            hit_found = 1'b1;
            hit_idx   = FRAME_BITS'(i);
          end
          if (!vic_found || rank_e[i] > vic_rank) begin
            vic_found = 1'b1;
            vic_idx   = FRAME_BITS'(i);
            vic_rank  = rank_e[i];
          end
        end else if (!emp_found) begin
          emp_found = 1'b1;
          emp_idx   = FRAME_BITS'(i);
        end
      end
    end
  end

  always_comb begin
    evict = 1'b0;
    priority if (hit_found) begin
      frame_sel = hit_idx;
      old_rank  = {1'b0, rank_e[hit_idx]};
    end else if (emp_found) begin
      frame_sel = emp_idx;
      old_rank  = (RANK_BITS + 1)'(MAX_FRAMES);
    end else begin
      frame_sel = vic_idx;
      old_rank  = {1'b0, vic_rank};
      evict     = 1'b1;
    end
    ev_page = evict ? frame_page_r[vic_idx] : '0;
  end

  always_comb begin
    frame_valid_nxt = vld_e;
    frame_valid_nxt[frame_sel] = 1'b1;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (FRAME_BITS'(i) == frame_sel) begin
        rank_nxt[i] = '0;
      end else if (vld_e[i] && ({1'b0, rank_e[i]} < old_rank) && (rank_e[i] < RANK_TOP)) begin
        rank_nxt[i] = rank_e[i] + RANK_BITS'(1);
      end else begin
        rank_nxt[i] = rank_e[i];
      end
    end
    faults_nxt = faults_e;
    repl_nxt   = repl_e;
    if (!hit_found && faults_e != '1) begin
      faults_nxt = faults_e + COUNT_BITS'(1);
    end
    if (evict && repl_e != '1) begin
      repl_nxt = repl_e + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r         <= FRAMES_IN_USE_RST;
      frame_valid_r <= '0;
      faults_r      <= '0;
      repl_r        <= '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (cmd.cfg_we) begin
        cfg_r <= cfg_data;
      end
      if (cmd.commit) begin
        frame_valid_r <= frame_valid_nxt;
        faults_r      <= faults_nxt;
        repl_r        <= repl_nxt;
        for (int i = 0; i < MAX_FRAMES; i++) begin
          rank_r[i] <= rank_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      restart_r <= in_restart;
      page_r    <= in_page_number;
    end
    if (cmd.commit) begin
      if (!hit_found) begin
        frame_page_r[frame_sel] <= page_r;
      end
      hit_r      <= hit_found;
      frame_r    <= frame_sel;
      ev_valid_r <= evict;
      ev_page_r  <= ev_page;
    end
  end

  assign out_hit           = hit_r;
  assign out_frame_index   = frame_r;
  assign out_evicted_valid = ev_valid_r;
  assign out_evicted_page  = ev_page_r;
  assign out_fault_count   = faults_r;
  assign out_replace_count = repl_r;

endmodule
